// ===== rtl/tist_pkg.sv =====
// Shared types and constants of the time interval set table.
// Used by the controller, the datapath and the top level.
`timescale 1ns / 1ps
`default_nettype none
package tist_pkg;

   localparam int DEF_MAX_INTERVALS = 64;
   localparam int DEF_TIME_BITS     = 48;
   localparam int IDX_W             = 6;
   localparam int ONT_W             = 54;
   localparam logic [ONT_W-1:0] ONT_MAX = '1;

   typedef enum logic [2:0] {
      K_CLEAR  = 3'd0,
      K_APPEND = 3'd1,
      K_INSERT = 3'd2,
      K_INSMRG = 3'd3,
      K_MERGE  = 3'd4,
      K_CLIP   = 3'd5,
      K_REMOVE = 3'd6,
      K_QUERY  = 3'd7
   } kind_type;

   typedef enum logic [1:0] {
      ST_OK    = 2'd0,
      ST_ORDER = 2'd1,
      ST_FULL  = 2'd2,
      ST_RANGE = 2'd3
   } status_type;

   typedef enum logic [2:0] {
      P_NONE,
      P_INS,
      P_MRG,
      P_CMP,
      P_QRY,
      P_SUM
   } pass_type;

   typedef enum logic [3:0] {
      S_IDLE,
      S_CHK,
      S_INS,
      S_INS_T,
      S_MRG,
      S_MRG_T,
      S_CMP,
      S_CMP_T,
      S_QRY,
      S_SUM,
      S_RESP
   } state_type;

   typedef struct packed {
      pass_type pass;
      logic     load;
      logic     begin_pass;
      logic     issue;
      logic     tail;
      logic     clear;
      logic     commit;
      logic     emit;
   } cmd_type;

   typedef struct packed {
      logic     err;
      kind_type kind;
      logic     rd_done;
      logic     pipe_busy;
      logic     rsp_free;
   } sts_type;

endpackage
`default_nettype wire

// ===== rtl/time_interval_set_table_unit.sv =====
// Time interval set table, top level: controller, datapath and table RAM.
// Depends on tist_pkg, tist_ctrl, tist_dp and tist_ram.
//
// Holds up to MAX_INTERVALS closed intervals in one RAM and runs one operation
// per request word: clear, append, sorted insert, insert and merge, merge all,
// clip, remove or query. Each walk over the table goes through the single RAM
// read port at one entry per cycle. Changing operations make one walk plus a
// summary walk (insert and merge makes two plus the summary, clear only the
// summary walk); a query makes one walk and a rejected request none. The
// response word is held in an output register, so the next request is taken
// while it waits. The table needs no clearing after reset.
`timescale 1ns / 1ps
`default_nettype none
module time_interval_set_table_unit import tist_pkg::*; #(
   parameter int MAX_INTERVALS = DEF_MAX_INTERVALS,
   parameter int TIME_BITS     = DEF_TIME_BITS,
   localparam int CNT_W = $clog2(MAX_INTERVALS + 1)
) (
   input  wire logic                 clock,
   input  wire logic                 reset,
   input  wire logic                 req_valid,
   output logic                      req_ready,
   input  wire logic [2:0]           req_kind,
   input  wire logic [TIME_BITS-1:0] req_interval_start,
   input  wire logic [TIME_BITS-1:0] req_interval_stop,
   input  wire logic [IDX_W-1:0]     req_entry_index,
   input  wire logic [TIME_BITS-1:0] req_query_time,
   output logic                      rsp_valid,
   input  wire logic                 rsp_ready,
   output logic [1:0]                rsp_status,
   output logic                      rsp_found,
   output logic [CNT_W-1:0]          rsp_count,
   output logic [TIME_BITS-1:0]      rsp_earliest_start,
   output logic [TIME_BITS-1:0]      rsp_latest_stop,
   output logic [TIME_BITS-1:0]      rsp_elapsed,
   output logic [ONT_W-1:0]          rsp_on_time
);

   localparam int AW = $clog2(MAX_INTERVALS);

   cmd_type                  cmd;
   sts_type                  sts;
   logic                     mem_wr_en, mem_rd_en;
   logic [AW-1:0]            mem_wr_addr, mem_rd_addr;
   logic [2*TIME_BITS-1:0]   mem_wr_data, mem_rd_data;

   tist_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_ready (req_ready),
      .sts       (sts),
      .cmd       (cmd)
   );

   tist_dp #(
      .MAX_INTERVALS (MAX_INTERVALS),
      .TIME_BITS     (TIME_BITS)
   ) u_dp (
      .clock              (clock),
      .reset              (reset),
      .cmd                (cmd),
      .sts                (sts),
      .req_kind           (req_kind),
      .req_interval_start (req_interval_start),
      .req_interval_stop  (req_interval_stop),
      .req_entry_index    (req_entry_index),
      .req_query_time     (req_query_time),
      .rsp_valid          (rsp_valid),
      .rsp_ready          (rsp_ready),
      .rsp_status         (rsp_status),
      .rsp_found          (rsp_found),
      .rsp_count          (rsp_count),
      .rsp_earliest_start (rsp_earliest_start),
      .rsp_latest_stop    (rsp_latest_stop),
      .rsp_elapsed        (rsp_elapsed),
      .rsp_on_time        (rsp_on_time),
      .mem_wr_en          (mem_wr_en),
      .mem_wr_addr        (mem_wr_addr),
      .mem_wr_data        (mem_wr_data),
      .mem_rd_en          (mem_rd_en),
      .mem_rd_addr        (mem_rd_addr),
      .mem_rd_data        (mem_rd_data)
   );

   tist_ram #(
      .WIDTH (2 * TIME_BITS),
      .DEPTH (MAX_INTERVALS)
   ) u_ram (
      .clock   (clock),
      .wr_en   (mem_wr_en),
      .wr_addr (mem_wr_addr),
      .wr_data (mem_wr_data),
      .rd_en   (mem_rd_en),
      .rd_addr (mem_rd_addr),
      .rd_data (mem_rd_data)
   );

   a_count_range: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> (rsp_count <= CNT_W'(MAX_INTERVALS)))
      else $error("count above table depth");

   a_found_nonempty: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && rsp_found) |-> (rsp_count != '0))
      else $error("found set on empty table");

   a_empty_summary: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && rsp_count == '0) |-> (rsp_on_time == '0 && rsp_earliest_start == '0
                                          && rsp_latest_stop == '0))
      else $error("summary not zero on empty table");

   a_busy_after_accept: assert property (@(posedge clock) disable iff (reset)
      (req_valid && req_ready) |=> !req_ready)
      else $error("request taken while busy");

endmodule
`default_nettype wire

// ===== rtl/tist_ram.sv =====
// Generic single write port, single read port RAM with registered read.
// No dependencies.
`timescale 1ns / 1ps
`default_nettype none
module tist_ram #(
   parameter int WIDTH = 96,
   parameter int DEPTH = 64
) (
   input  wire logic                     clock,
   input  wire logic                     wr_en,
   input  wire logic [$clog2(DEPTH)-1:0] wr_addr,
   input  wire logic [WIDTH-1:0]         wr_data,
   input  wire logic                     rd_en,
   input  wire logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic      [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data <= mem_ff[rd_addr];
      end
   end

endmodule
`default_nettype wire

// ===== rtl/tist_ctrl.sv =====
// Sequencing state machine of the time interval set table.
// Depends on tist_pkg; drives the datapath through cmd_type.
`timescale 1ns / 1ps
`default_nettype none
module tist_ctrl import tist_pkg::*; (
   input  wire logic    clock,
   input  wire logic    reset,
   input  wire logic    req_valid,
   output logic         req_ready,
   input  wire sts_type sts,
   output cmd_type      cmd
);

   state_type state_ff, state_in;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

   always_comb begin
      state_in  = state_ff;
      cmd       = '0;
      cmd.pass  = P_NONE;
      req_ready = 1'b0;
      case (state_ff)
         S_IDLE: begin
            req_ready = 1'b1;
            if (req_valid) begin
               cmd.load = 1'b1;
               state_in = S_CHK;
            end
         end
         S_CHK: begin
            cmd.begin_pass = 1'b1;
            if (sts.err) begin
               state_in = S_RESP;
            end else begin
               case (sts.kind)
                  K_CLEAR: begin
                     cmd.clear = 1'b1;
                     state_in  = S_SUM;
                  end
                  K_APPEND, K_INSERT, K_INSMRG: state_in = S_INS;
                  K_MERGE:                      state_in = S_MRG;
                  K_CLIP, K_REMOVE:             state_in = S_CMP;
                  K_QUERY:                      state_in = S_QRY;
                  default:                      state_in = S_RESP;
               endcase
            end
         end
         S_INS, S_MRG, S_CMP, S_QRY, S_SUM: begin
            case (state_ff)
               S_INS:   cmd.pass = P_INS;
               S_MRG:   cmd.pass = P_MRG;
               S_CMP:   cmd.pass = P_CMP;
               S_QRY:   cmd.pass = P_QRY;
               default: cmd.pass = P_SUM;
            endcase
            cmd.issue = !sts.rd_done;
            if (sts.rd_done && !sts.pipe_busy) begin
               case (state_ff)
                  S_INS:   state_in = S_INS_T;
                  S_MRG:   state_in = S_MRG_T;
                  S_CMP:   state_in = S_CMP_T;
                  S_QRY:   state_in = S_RESP;
                  default: begin
                     cmd.commit = 1'b1;
                     state_in   = S_RESP;
                  end
               endcase
            end
         end
         S_INS_T: begin
            cmd.pass       = P_INS;
            cmd.tail       = 1'b1;
            cmd.begin_pass = 1'b1;
            state_in       = (sts.kind == K_INSMRG) ? S_MRG : S_SUM;
         end
         S_MRG_T: begin
            cmd.pass       = P_MRG;
            cmd.tail       = 1'b1;
            cmd.begin_pass = 1'b1;
            state_in       = S_SUM;
         end
         S_CMP_T: begin
            cmd.pass       = P_CMP;
            cmd.tail       = 1'b1;
            cmd.begin_pass = 1'b1;
            state_in       = S_SUM;
         end
         S_RESP: begin
            if (sts.rsp_free) begin
               cmd.emit = 1'b1;
               state_in = S_IDLE;
            end
         end
         default: state_in = S_IDLE;
      endcase
   end

endmodule
`default_nettype wire

// ===== rtl/tist_dp.sv =====
// Datapath of the time interval set table: request latch, table walk,
// summary accumulation and result word. Depends on tist_pkg; drives the table RAM ports.
`timescale 1ns / 1ps
`default_nettype none
module tist_dp import tist_pkg::*; #(
   parameter int MAX_INTERVALS = DEF_MAX_INTERVALS,
   parameter int TIME_BITS     = DEF_TIME_BITS,
   localparam int AW    = $clog2(MAX_INTERVALS),
   localparam int CNT_W = $clog2(MAX_INTERVALS + 1)
) (
   input  wire logic                   clock,
   input  wire logic                   reset,
   input  wire cmd_type                cmd,
   output sts_type                     sts,
   input  wire logic [2:0]             req_kind,
   input  wire logic [TIME_BITS-1:0]   req_interval_start,
   input  wire logic [TIME_BITS-1:0]   req_interval_stop,
   input  wire logic [IDX_W-1:0]       req_entry_index,
   input  wire logic [TIME_BITS-1:0]   req_query_time,
   output logic                        rsp_valid,
   input  wire logic                   rsp_ready,
   output logic [1:0]                  rsp_status,
   output logic                        rsp_found,
   output logic [CNT_W-1:0]            rsp_count,
   output logic [TIME_BITS-1:0]        rsp_earliest_start,
   output logic [TIME_BITS-1:0]        rsp_latest_stop,
   output logic [TIME_BITS-1:0]        rsp_elapsed,
   output logic [ONT_W-1:0]            rsp_on_time,
   output logic                        mem_wr_en,
   output logic [AW-1:0]               mem_wr_addr,
   output logic [2*TIME_BITS-1:0]      mem_wr_data,
   output logic                        mem_rd_en,
   output logic [AW-1:0]               mem_rd_addr,
   input  wire logic [2*TIME_BITS-1:0] mem_rd_data
);

   localparam int T     = TIME_BITS;
   localparam int CMP_W = (CNT_W > IDX_W) ? CNT_W : IDX_W;
   localparam int SW    = ((T > ONT_W) ? T : ONT_W) + 1;
   localparam logic [CNT_W-1:0] MAX_CNT = CNT_W'(MAX_INTERVALS);
   localparam logic [CNT_W-1:0] ONE_CNT = CNT_W'(1);

   kind_type         kind_ff, kind_in;
   status_type       status_ff, status_in;
   logic [T-1:0]     s_ff, s_in, e_ff, e_in, q_ff, q_in;
   logic [IDX_W-1:0] idx_ff, idx_in;
   logic             found_ff, found_in;
   logic [CNT_W-1:0] count_ff, count_in, rcnt_ff, rcnt_in, wcnt_ff, wcnt_in;
   logic             pv_ff, pv_in;
   logic [AW-1:0]    pidx_ff, pidx_in;
   logic             ins_ff, ins_in;
   logic [T-1:0]     cs_ff, cs_in, ce_ff, ce_in;
   logic [T-1:0]     as_ff, as_in, ae_ff, ae_in;
   logic [T-1:0]     mn_ff, mn_in, mx_ff, mx_in;
   logic [ONT_W-1:0] sm_ff, sm_in;
   logic [T-1:0]     min_ff, min_in, max_ff, max_in;
   logic [ONT_W-1:0] sum_ff, sum_in;
   logic             rv_ff, rv_in;
   logic [1:0]       rst_ff, rst_in;
   logic             rfd_ff, rfd_in;
   logic [CNT_W-1:0] rcn_ff, rcn_in;
   logic [T-1:0]     res_ff, res_in, rls_ff, rls_in, rel_ff, rel_in;
   logic [ONT_W-1:0] ron_ff, ron_in;

   logic [T-1:0]     rs, re, cls, cle, len;
   logic [SW-1:0]    sum_ext;
   logic             keep;
   logic [T-1:0]     rq_s, rq_e;

   assign rs = mem_rd_data[2*T-1:T];
   assign re = mem_rd_data[T-1:0];
   assign cls = (rs < s_ff) ? s_ff : rs;
   assign cle = (re > e_ff) ? e_ff : re;
   assign len = (re >= rs) ? (re - rs) : '0;
   assign sum_ext = SW'(sm_ff) + SW'(len);
   assign rq_s = req_interval_start;
   assign rq_e = req_interval_stop;

   assign mem_rd_en   = cmd.issue;
   assign mem_rd_addr = rcnt_ff[AW-1:0];

   assign sts.err       = (status_ff != ST_OK);
   assign sts.kind      = kind_ff;
   assign sts.rd_done   = (rcnt_ff == count_ff);
   assign sts.pipe_busy = pv_ff;
   assign sts.rsp_free  = !rv_ff || rsp_ready;

   always_comb begin
      kind_in = kind_ff; status_in = status_ff; s_in = s_ff; e_in = e_ff; q_in = q_ff;
      idx_in = idx_ff; found_in = found_ff; count_in = count_ff;
      rcnt_in = rcnt_ff; wcnt_in = wcnt_ff; pv_in = cmd.issue; pidx_in = rcnt_ff[AW-1:0];
      ins_in = ins_ff; cs_in = cs_ff; ce_in = ce_ff; as_in = as_ff; ae_in = ae_ff;
      mn_in = mn_ff; mx_in = mx_ff; sm_in = sm_ff;
      min_in = min_ff; max_in = max_ff; sum_in = sum_ff;
      rv_in = rv_ff && !rsp_ready; rst_in = rst_ff; rfd_in = rfd_ff; rcn_in = rcn_ff;
      res_in = res_ff; rls_in = rls_ff; rel_in = rel_ff; ron_in = ron_ff;
      mem_wr_en = 1'b0; mem_wr_addr = '0; mem_wr_data = '0;
      keep = 1'b0;

      if (cmd.load) begin
         kind_in   = kind_type'(req_kind);
         s_in      = rq_s;
         e_in      = rq_e;
         q_in      = req_query_time;
         idx_in    = req_entry_index;
         found_in  = 1'b0;
         status_in = ST_OK;
         case (kind_type'(req_kind))
            K_APPEND, K_INSERT, K_INSMRG: begin
               if (rq_s > rq_e) status_in = ST_ORDER;
               else if (count_ff >= MAX_CNT) status_in = ST_FULL;
            end
            K_CLIP: begin
               if (rq_s > rq_e) status_in = ST_ORDER;
            end
            K_REMOVE: begin
               if (CMP_W'(req_entry_index) >= CMP_W'(count_ff)) status_in = ST_RANGE;
            end
            default: status_in = ST_OK;
         endcase
      end

      if (cmd.issue) begin
         rcnt_in = rcnt_ff + ONE_CNT;
      end

      if (pv_ff) begin
         case (cmd.pass)
            P_INS: begin
               if (ins_ff) begin
                  mem_wr_en   = 1'b1;
                  mem_wr_addr = pidx_ff;
                  mem_wr_data = {cs_ff, ce_ff};
                  cs_in = rs;
                  ce_in = re;
               end else if (kind_ff != K_APPEND && s_ff < rs) begin
                  mem_wr_en   = 1'b1;
                  mem_wr_addr = pidx_ff;
                  mem_wr_data = {s_ff, e_ff};
                  cs_in  = rs;
                  ce_in  = re;
                  ins_in = 1'b1;
               end
            end
            P_MRG: begin
               if (pidx_ff == '0) begin
                  as_in = rs;
                  ae_in = re;
               end else if (rs <= ae_ff) begin
                  if (rs < as_ff) as_in = rs;
                  if (re > ae_ff) ae_in = re;
               end else begin
                  mem_wr_en   = 1'b1;
                  mem_wr_addr = wcnt_ff[AW-1:0];
                  mem_wr_data = {as_ff, ae_ff};
                  wcnt_in     = wcnt_ff + ONE_CNT;
                  as_in       = rs;
                  ae_in       = re;
               end
            end
            P_CMP: begin
               if (kind_ff == K_CLIP) begin
                  keep        = (cls <= cle);
                  mem_wr_data = {cls, cle};
               end else begin
                  keep        = (CMP_W'(pidx_ff) != CMP_W'(idx_ff));
                  mem_wr_data = mem_rd_data;
               end
               if (keep) begin
                  mem_wr_en   = 1'b1;
                  mem_wr_addr = wcnt_ff[AW-1:0];
                  wcnt_in     = wcnt_ff + ONE_CNT;
               end
            end
            P_QRY: begin
               if (q_ff >= rs && q_ff <= re) found_in = 1'b1;
            end
            P_SUM: begin
               if (pidx_ff == '0) begin
                  mn_in = rs;
                  mx_in = re;
               end else begin
                  if (rs < mn_ff) mn_in = rs;
                  if (re > mx_ff) mx_in = re;
               end
               sm_in = (sum_ext > SW'(ONT_MAX)) ? ONT_MAX : sum_ext[ONT_W-1:0];
            end
            default: ;
         endcase
      end

      if (cmd.tail) begin
         case (cmd.pass)
            P_INS: begin
               mem_wr_en   = 1'b1;
               mem_wr_addr = count_ff[AW-1:0];
               mem_wr_data = ins_ff ? {cs_ff, ce_ff} : {s_ff, e_ff};
               count_in    = count_ff + ONE_CNT;
            end
            P_MRG: begin
               if (count_ff != '0) begin
                  mem_wr_en   = 1'b1;
                  mem_wr_addr = wcnt_ff[AW-1:0];
                  mem_wr_data = {as_ff, ae_ff};
                  count_in    = wcnt_ff + ONE_CNT;
               end
            end
            default: count_in = wcnt_ff;
         endcase
      end

      if (cmd.begin_pass) begin
         rcnt_in = '0;
         wcnt_in = '0;
         ins_in  = 1'b0;
         mn_in   = '0;
         mx_in   = '0;
         sm_in   = '0;
      end

      if (cmd.clear) begin
         count_in = '0;
      end

      if (cmd.commit) begin
         min_in = mn_ff;
         max_in = mx_ff;
         sum_in = sm_ff;
      end

      if (cmd.emit) begin
         rv_in  = 1'b1;
         rst_in = status_ff;
         rfd_in = found_ff;
         rcn_in = count_ff;
         res_in = min_ff;
         rls_in = max_ff;
         rel_in = (max_ff >= min_ff) ? (max_ff - min_ff) : '0;
         ron_in = sum_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         count_ff <= '0;
         pv_ff    <= 1'b0;
         rv_ff    <= 1'b0;
         min_ff   <= '0;
         max_ff   <= '0;
         sum_ff   <= '0;
      end else begin
         count_ff <= count_in;
         pv_ff    <= pv_in;
         rv_ff    <= rv_in;
         min_ff   <= min_in;
         max_ff   <= max_in;
         sum_ff   <= sum_in;
      end
   end

   always_ff @(posedge clock) begin
      kind_ff <= kind_in; status_ff <= status_in;
      s_ff <= s_in; e_ff <= e_in; q_ff <= q_in; idx_ff <= idx_in;
      found_ff <= found_in; rcnt_ff <= rcnt_in; wcnt_ff <= wcnt_in;
      pidx_ff <= pidx_in; ins_ff <= ins_in;
      cs_ff <= cs_in; ce_ff <= ce_in; as_ff <= as_in; ae_ff <= ae_in;
      mn_ff <= mn_in; mx_ff <= mx_in; sm_ff <= sm_in;
      rst_ff <= rst_in; rfd_ff <= rfd_in; rcn_ff <= rcn_in;
      res_ff <= res_in; rls_ff <= rls_in; rel_ff <= rel_in; ron_ff <= ron_in;
   end

   assign rsp_valid          = rv_ff;
   assign rsp_status         = rst_ff;
   assign rsp_found          = rfd_ff;
   assign rsp_count          = rcn_ff;
   assign rsp_earliest_start = res_ff;
   assign rsp_latest_stop    = rls_ff;
   assign rsp_elapsed        = rel_ff;
   assign rsp_on_time        = ron_ff;

endmodule
`default_nettype wire
